// ===== rtl/ihex_pkg.sv =====
// Shared types, constants and a helper function for the Intel HEX record parser.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ACC_W   = 16;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned TDATA_W = 32;

    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LOW_F  = 8'h66;
    localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_F   = 8'h46;
    localparam logic [CH_W-1:0] CH_LF     = 8'h0A;

    localparam logic [CNT_W-1:0] CNT_BYTE = 3'd2;
    localparam logic [CNT_W-1:0] CNT_ADDR = 3'd4;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_COUNT = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_SKIP  = 3'd5,
        PH_ERR   = 3'd6
    } ihex_phase_t;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0] data_byte;
        logic              section_start;
    } ihex_result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } ihex_digit_t;

    function automatic ihex_digit_t hex_decode(input logic [CH_W-1:0] c);
        ihex_digit_t d;
        logic [CH_W-1:0] diff;
        d.is_hex = 1'b0;
        d.value  = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff     = c - CH_ZERO;
            d.is_hex = 1'b1;
            d.value  = diff[3:0];
        end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            diff     = c - CH_LOW_A + 8'd10;
            d.is_hex = 1'b1;
            d.value  = diff[3:0];
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            diff     = c - CH_UP_A + 8'd10;
            d.is_hex = 1'b1;
            d.value  = diff[3:0];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ihex_parse.sv =====
// Record parser state and its update for one character.
`timescale 1ns / 1ps
`default_nettype none

module ihex_parse (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [ihex_pkg::CH_W-1:0] ch,
    output ihex_pkg::ihex_result_t         result
);

    ihex_pkg::ihex_phase_t phase_reg, phase_next;
    logic [ihex_pkg::CNT_W-1:0]  digit_count_reg, digit_count_next;
    logic [ihex_pkg::ACC_W-1:0]  field_accum_reg, field_accum_next;
    logic [ihex_pkg::BYTE_W-1:0] record_length_reg, record_length_next;
    logic [ihex_pkg::ADDR_W-1:0] record_address_reg, record_address_next;
    logic [ihex_pkg::BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [ihex_pkg::ADDR_W:0]   expected_address_reg, expected_address_next;
    logic                        section_pending_reg, section_pending_next;

    ihex_pkg::ihex_digit_t       digit;
    logic [ihex_pkg::ACC_W-1:0]  accum_shift;
    logic [ihex_pkg::CNT_W-1:0]  count_inc;
    logic                        byte_done;
    logic                        addr_done;
    logic                        type_zero;
    logic                        in_field;

    assign digit       = ihex_pkg::hex_decode(ch);
    assign accum_shift = {field_accum_reg[ihex_pkg::ACC_W-5:0], digit.value};
    assign count_inc   = digit_count_reg + 3'd1;
    assign byte_done   = (count_inc == ihex_pkg::CNT_BYTE);
    assign addr_done   = (count_inc == ihex_pkg::CNT_ADDR);
    assign type_zero   = (accum_shift[7:0] == 8'd0);
    assign in_field    = (phase_reg == ihex_pkg::PH_COUNT) || (phase_reg == ihex_pkg::PH_ADDR)
                      || (phase_reg == ihex_pkg::PH_TYPE) || (phase_reg == ihex_pkg::PH_DATA);

    always_comb
    begin
        phase_next = phase_reg;
        if (step) begin
            unique case (phase_reg)
                ihex_pkg::PH_ERR:
                begin
                    phase_next = ihex_pkg::PH_ERR;
                end
                ihex_pkg::PH_SKIP:
                begin
                    if (ch == ihex_pkg::CH_LF) begin
                        phase_next = ihex_pkg::PH_IDLE;
                    end
                end
                ihex_pkg::PH_COUNT:
                begin
                    if (!digit.is_hex) begin
                        phase_next = ihex_pkg::PH_ERR;
                    end else if (byte_done) begin
                        phase_next = ihex_pkg::PH_ADDR;
                    end
                end
                ihex_pkg::PH_ADDR:
                begin
                    if (!digit.is_hex) begin
                        phase_next = ihex_pkg::PH_ERR;
                    end else if (addr_done) begin
                        phase_next = ihex_pkg::PH_TYPE;
                    end
                end
                ihex_pkg::PH_TYPE:
                begin
                    if (!digit.is_hex) begin
                        phase_next = ihex_pkg::PH_ERR;
                    end else if (byte_done) begin
                        if (type_zero && record_length_reg != 8'd0) begin
                            phase_next = ihex_pkg::PH_DATA;
                        end else begin
                            phase_next = ihex_pkg::PH_SKIP;
                        end
                    end
                end
                ihex_pkg::PH_DATA:
                begin
                    if (!digit.is_hex) begin
                        phase_next = ihex_pkg::PH_ERR;
                    end else if (byte_done && bytes_left_reg == 8'd1) begin
                        phase_next = ihex_pkg::PH_SKIP;
                    end
                end
                default:
                begin
                    if (ch == ihex_pkg::CH_COLON) begin
                        phase_next = ihex_pkg::PH_COUNT;
                    end else begin
                        phase_next = ihex_pkg::PH_ERR;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        digit_count_next      = digit_count_reg;
        field_accum_next      = field_accum_reg;
        record_length_next    = record_length_reg;
        record_address_next   = record_address_reg;
        bytes_left_next       = bytes_left_reg;
        expected_address_next = expected_address_reg;
        section_pending_next  = section_pending_reg;
        if (step) begin
            if (phase_reg == ihex_pkg::PH_IDLE && ch == ihex_pkg::CH_COLON) begin
                digit_count_next = '0;
                field_accum_next = '0;
            end else if (in_field && digit.is_hex) begin
                digit_count_next = count_inc;
                field_accum_next = accum_shift;
                unique case (phase_reg)
                    ihex_pkg::PH_COUNT:
                    begin
                        if (byte_done) begin
                            record_length_next = accum_shift[7:0];
                            digit_count_next   = '0;
                            field_accum_next   = '0;
                        end
                    end
                    ihex_pkg::PH_ADDR:
                    begin
                        if (addr_done) begin
                            record_address_next = accum_shift;
                            digit_count_next    = '0;
                            field_accum_next    = '0;
                        end
                    end
                    ihex_pkg::PH_TYPE:
                    begin
                        if (byte_done) begin
                            digit_count_next = '0;
                            field_accum_next = '0;
                            if (type_zero) begin
                                if ({1'b0, record_address_reg} != expected_address_reg) begin
                                    section_pending_next = 1'b1;
                                end
                                expected_address_next = {1'b0, record_address_reg}
                                                      + {9'd0, record_length_reg};
                                bytes_left_next = record_length_reg;
                            end
                        end
                    end
                    default:
                    begin
                        if (byte_done) begin
                            section_pending_next = 1'b0;
                            record_address_next  = record_address_reg + 16'd1;
                            bytes_left_next      = bytes_left_reg - 8'd1;
                            digit_count_next     = '0;
                            field_accum_next     = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result = '0;
        if (step) begin
            if ((phase_reg == ihex_pkg::PH_IDLE && ch != ihex_pkg::CH_COLON)
                || (in_field && !digit.is_hex)) begin
                result.valid = 1'b1;
                result.kind  = ihex_pkg::KIND_ERROR;
            end else if (phase_reg == ihex_pkg::PH_DATA && byte_done) begin
                result.valid         = 1'b1;
                result.kind          = ihex_pkg::KIND_DATA;
                result.byte_address  = record_address_reg;
                result.data_byte     = accum_shift[7:0];
                result.section_start = section_pending_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg            <= ihex_pkg::PH_IDLE;
            digit_count_reg      <= '0;
            field_accum_reg      <= '0;
            record_length_reg    <= '0;
            record_address_reg   <= '0;
            bytes_left_reg       <= '0;
            expected_address_reg <= '0;
            section_pending_reg  <= 1'b0;
        end else begin
            phase_reg            <= phase_next;
            digit_count_reg      <= digit_count_next;
            field_accum_reg      <= field_accum_next;
            record_length_reg    <= record_length_next;
            record_address_reg   <= record_address_next;
            bytes_left_reg       <= bytes_left_next;
            expected_address_reg <= expected_address_next;
            section_pending_reg  <= section_pending_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/intel_hex_record_parser_unit.sv =====
// Top level of the Intel HEX record parser: input register, parser and result register.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[7:0] = ch
//   m_axis   out        tdata = byte_address, data_byte, section_start; tuser = kind
//
// One character is taken per cycle unless a stalled result holds the flow. Each character
// moves from the input register through the parser, which updates its state on that move;
// any result is registered after it, so unstalled throughput is one character per clock.
// Reset is asynchronous and active low; it empties both registers and the parser.
// A stalled result holds its register, and the input register fills behind it.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_parser_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output      logic                         s_axis_tready,
    input  wire logic [ihex_pkg::CH_W-1:0]    s_axis_tdata,   // [7:0] ch
    output      logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output      logic [ihex_pkg::TDATA_W-1:0] m_axis_tdata,   // [15:0] byte_address,
                                                              // [23:16] data_byte,
                                                              // [24] section_start
    output      logic [0:0]                   m_axis_tuser    // [0] kind
);

    logic                        in_valid_reg, in_valid_next;
    logic [ihex_pkg::CH_W-1:0]   in_ch_reg;
    logic                        out_valid_reg, out_valid_next;
    ihex_pkg::ihex_result_t      out_reg;
    ihex_pkg::ihex_result_t      result;
    logic                        advance;
    logic                        s_accept;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    ihex_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ch     (in_ch_reg),
        .result (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = result.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_ch_reg <= s_axis_tdata;
        end
        if (advance && result.valid)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.section_start, out_reg.data_byte,
                            out_reg.byte_address};
    assign m_axis_tuser  = out_reg.kind;

endmodule

`default_nettype wire

// ===== rtl/ihex_checker.sv =====
// Port-level checks for the Intel HEX record parser and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ihex_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [ihex_pkg::TDATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]                   m_axis_tuser
);

    logic err_done_reg;
    logic err_take;

    assign err_take = m_axis_tvalid && m_axis_tready
                   && (m_axis_tuser[0] == ihex_pkg::KIND_ERROR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_done_reg <= 1'b0;
        end
        else if (err_take)
        begin
            err_done_reg <= 1'b1;
        end
    end

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !(err_done_reg && m_axis_tvalid))
        else $error("Result delivered after a format error.");

    a_error_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0] == ihex_pkg::KIND_ERROR) |-> (m_axis_tdata == '0))
        else $error("Format error result carries a nonzero payload.");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ihex_pkg::TDATA_W-1:25] == '0))
        else $error("Padding bits of a result are not zero.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("Stalled result changed or dropped.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && !m_axis_tvalid) |-> s_axis_tready)
        else $error("Request refused while the result register is empty.");

endmodule

bind intel_hex_record_parser_unit ihex_checker u_ihex_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the Intel HEX record parser unit.
`timescale 1ns / 1ps

module testbench;

    localparam int ITEMS      = 1600;
    localparam int STALL_MAX  = 3000;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 150;
    localparam int CALM_FROM  = 900;
    localparam int CALM_TO    = 1300;
    localparam int IDLE_PCT   = 12;

    typedef struct packed {
        logic                        kind;
        logic [ihex_pkg::ADDR_W-1:0] address;
        logic [ihex_pkg::BYTE_W-1:0] value;
        logic                        section;
    } parse_result_t;

    class ihex_tracker;
        ihex_pkg::ihex_phase_t       phase;
        logic [ihex_pkg::CNT_W-1:0]  digits;
        logic [ihex_pkg::ACC_W-1:0]  accum;
        logic [7:0]                  rec_len;
        logic [ihex_pkg::ADDR_W-1:0] rec_addr;
        logic [7:0]                  left;
        logic [ihex_pkg::ADDR_W:0]   next_addr;
        logic                        pending;
        parse_result_t               due_results[$];
        int                          mismatches;
        int                          bytes_checked;
        int                          starts_checked;
        bit                          error_seen;

        function new();
            phase          = ihex_pkg::PH_IDLE;
            digits         = '0;
            accum          = '0;
            rec_len        = '0;
            rec_addr       = '0;
            left           = '0;
            next_addr      = '0;
            pending        = 1'b0;
            mismatches     = 0;
            bytes_checked  = 0;
            starts_checked = 0;
            error_seen     = 1'b0;
        endfunction

        function void flag_format_error();
            parse_result_t r;
            r           = '0;
            r.kind      = ihex_pkg::KIND_ERROR;
            phase       = ihex_pkg::PH_ERR;
            due_results = {due_results, r};
        endfunction

        function void note_char(logic [ihex_pkg::CH_W-1:0] c);
            logic [3:0]    nib;
            logic          ok;
            parse_result_t r;
            ok  = 1'b1;
            nib = 4'd0;
            if (c >= ihex_pkg::CH_ZERO && c <= ihex_pkg::CH_NINE)
                nib = 4'(c - ihex_pkg::CH_ZERO);
            else if (c >= ihex_pkg::CH_LOW_A && c <= ihex_pkg::CH_LOW_F)
                nib = 4'(c - ihex_pkg::CH_LOW_A + 8'd10);
            else if (c >= ihex_pkg::CH_UP_A && c <= ihex_pkg::CH_UP_F)
                nib = 4'(c - ihex_pkg::CH_UP_A + 8'd10);
            else
                ok = 1'b0;
            case (phase)
                ihex_pkg::PH_ERR: ;
                ihex_pkg::PH_SKIP:
                begin
                    if (c == ihex_pkg::CH_LF)
                        phase = ihex_pkg::PH_IDLE;
                end
                ihex_pkg::PH_COUNT, ihex_pkg::PH_ADDR, ihex_pkg::PH_TYPE, ihex_pkg::PH_DATA:
                begin
                    if (!ok)
                        flag_format_error();
                    else
                    begin
                        accum  = {accum[ihex_pkg::ACC_W-5:0], nib};
                        digits = digits + 3'd1;
                        if (phase == ihex_pkg::PH_COUNT && digits == ihex_pkg::CNT_BYTE)
                        begin
                            rec_len = accum[7:0];
                            accum   = '0;
                            digits  = '0;
                            phase   = ihex_pkg::PH_ADDR;
                        end
                        else if (phase == ihex_pkg::PH_ADDR && digits == ihex_pkg::CNT_ADDR)
                        begin
                            rec_addr = accum;
                            accum    = '0;
                            digits   = '0;
                            phase    = ihex_pkg::PH_TYPE;
                        end
                        else if (phase == ihex_pkg::PH_TYPE && digits == ihex_pkg::CNT_BYTE)
                        begin
                            digits = '0;
                            if (accum[7:0] != 8'd0)
                                phase = ihex_pkg::PH_SKIP;
                            else
                            begin
                                if ({1'b0, rec_addr} != next_addr)
                                    pending = 1'b1;
                                next_addr = {1'b0, rec_addr} + {9'd0, rec_len};
                                left      = rec_len;
                                phase     = (rec_len != 8'd0) ? ihex_pkg::PH_DATA
                                                              : ihex_pkg::PH_SKIP;
                            end
                            accum = '0;
                        end
                        else if (phase == ihex_pkg::PH_DATA && digits == ihex_pkg::CNT_BYTE)
                        begin
                            r.kind      = ihex_pkg::KIND_DATA;
                            r.address   = rec_addr;
                            r.value     = accum[7:0];
                            r.section   = pending;
                            due_results = {due_results, r};
                            pending  = 1'b0;
                            rec_addr = rec_addr + 16'd1;
                            left     = left - 8'd1;
                            accum    = '0;
                            digits   = '0;
                            if (left == 8'd0)
                                phase = ihex_pkg::PH_SKIP;
                        end
                    end
                end
                default:
                begin
                    if (c != ihex_pkg::CH_COLON)
                        flag_format_error();
                    else
                    begin
                        phase  = ihex_pkg::PH_COUNT;
                        digits = '0;
                        accum  = '0;
                    end
                end
            endcase
        endfunction

        function void check_result(logic [ihex_pkg::TDATA_W-1:0] tdata,
                                   logic [0:0] tuser);
            parse_result_t got;
            parse_result_t want;
            got.kind    = tuser[0];
            got.address = tdata[15:0];
            got.value   = tdata[23:16];
            got.section = tdata[24];
            if (due_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result kind=%0d addr=%h byte=%h start=%0d",
                         $time, got.kind, got.address, got.value, got.section);
            end
            else
            begin
                want = due_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    $display("%0t: expected k=%0d a=%h d=%h s=%0d, got k=%0d a=%h d=%h s=%0d",
                             $time, want.kind, want.address, want.value, want.section,
                             got.kind, got.address, got.value, got.section);
                end
                if (want.kind == ihex_pkg::KIND_ERROR)
                    error_seen = 1'b1;
                else
                begin
                    bytes_checked++;
                    if (want.section)
                        starts_checked++;
                end
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ihex_pkg::CH_W-1:0]     s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ihex_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]                    m_axis_tuser;

    ihex_tracker                   board;
    int                            cyc = 0;
    int                            stall = 0;
    int                            chars_sent = 0;
    logic [ihex_pkg::ADDR_W-1:0]   gen_next = '0;
    logic                          calm;

    assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    intel_hex_record_parser_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cyc <= cyc + 1;
            if (s_axis_tvalid && s_axis_tready)
                board.note_char(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall <= 0;
            else if (stall >= STALL_MAX)
            begin
                $display("%0t: no request or result moved for %0d cycles", $time, stall);
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                stall <= stall + 1;
        end
    end

    initial
    begin
        int held;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (cyc == HOLD_AT)
            begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_LEN; held++)
                    @(negedge clk);
            end
            if (calm)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_char(input logic [ihex_pkg::CH_W-1:0] c);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_hex(input int value, input int count);
        int         i;
        logic [3:0] nib;
        logic [7:0] base;
        for (i = count - 1; i >= 0; i--)
        begin
            nib = 4'(value >> (4 * i));
            base = $urandom_range(1) ? ihex_pkg::CH_LOW_A : ihex_pkg::CH_UP_A;
            if (nib < 4'd10)
                send_char(ihex_pkg::CH_ZERO + {4'd0, nib});
            else
                send_char(base + {4'd0, nib} - 8'd10);
        end
    endtask

    task automatic send_record(input int len, input int addr, input int rtype, input int fill);
        int         i;
        int         extra;
        logic [7:0] c;
        send_char(ihex_pkg::CH_COLON);
        send_hex(len, 2);
        send_hex(addr, 4);
        send_hex(rtype, 2);
        for (i = 0; i < len; i++)
            send_hex((fill < 0) ? $urandom_range(255) : fill, 2);
        send_hex($urandom_range(255), 2);
        if ($urandom_range(1))
            send_char(8'h0D);
        extra = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
        for (i = 0; i < extra; i++)
        begin
            c = 8'($urandom_range(255));
            send_char((c == ihex_pkg::CH_LF) ? 8'h80 : c);
        end
        send_char(ihex_pkg::CH_LF);
        if (rtype == 0)
            gen_next = 16'(addr + len);
    endtask

    // Ends the file with one malformed line and one more record line after it; the error is sticky, so this comes last.
    task automatic break_stream();
        int         how;
        int         len;
        int         cut;
        int         i;
        logic [7:0] c;
        logic [3:0] nibs[$];
        how = $urandom_range(3);
        len = $urandom_range(1, 4);
        c   = 8'($urandom_range(255));
        if ((c >= ihex_pkg::CH_ZERO && c <= ihex_pkg::CH_NINE) ||
            (c >= ihex_pkg::CH_UP_A && c <= ihex_pkg::CH_UP_F) ||
            (c >= ihex_pkg::CH_LOW_A && c <= ihex_pkg::CH_LOW_F))
            c = c ^ 8'h40;
        for (i = 1; i >= 0; i--)
            nibs = {nibs, 4'(len >> (4 * i))};
        for (i = 3; i >= 0; i--)
            nibs = {nibs, gen_next[4*i +: 4]};
        nibs = {nibs, 4'd0};
        nibs = {nibs, 4'd0};
        for (i = 0; i < 2 * len; i++)
            nibs = {nibs, 4'($urandom_range(15))};
        case (how)
            0: send_char(ihex_pkg::CH_LF);
            1: send_char((c == ihex_pkg::CH_COLON) ? 8'h3B : c);
            default:
            begin
                cut = (how == 2) ? $urandom_range(nibs.size() - 1)
                                 : 8 + $urandom_range(2 * len - 1);
                send_char(ihex_pkg::CH_COLON);
                for (i = 0; i < cut; i++)
                    send_hex(nibs[i], 1);
                send_char((how == 2) ? c : ihex_pkg::CH_LF);
            end
        endcase
        send_char(ihex_pkg::CH_COLON);
        for (i = 0; i < 12; i++)
            send_hex($urandom_range(15), 1);
        send_char(ihex_pkg::CH_LF);
    endtask

    initial
    begin
        int pick;
        int len;
        int addr;
        int rtype;
        board = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_record(1, 16'h0000, 0, 8'h00);
        send_record(1, 16'h0001, 0, 8'hFF);
        send_record(2, 16'hFFFF, 0, -1);
        send_record(1, 16'h0001, 0, -1);
        send_record(0, 16'h1234, 0, 0);
        send_record(1, 16'h0040, 1, -1);
        send_record(1, 16'h1234, 0, -1);
        send_record(0, 16'h8000, 0, 0);
        send_record(0, 16'h9000, 0, 0);
        send_record(1, 16'h9000, 0, -1);
        send_record(1, 16'h0000, 255, -1);

        while (chars_sent < ITEMS)
        begin
            pick  = $urandom_range(99);
            len   = ($urandom_range(99) < 2) ? $urandom_range(64, 255) : $urandom_range(8);
            rtype = ($urandom_range(99) < 8) ? $urandom_range(1, 255) : 0;
            if (pick < 60)
                addr = gen_next;
            else if (pick < 72)
                addr = 16'hFFF0 + $urandom_range(15);
            else
                addr = $urandom_range(16'hFFFF);
            send_record(len, addr, rtype, -1);
        end
        break_stream();
        s_axis_tvalid <= 1'b0;

        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d characters; checked %0d data bytes, %0d of them section starts.",
                 chars_sent, board.bytes_checked, board.starts_checked);
        $display("Format error reported: %0d, mismatches: %0d.",
                 board.error_seen, board.mismatches);
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== intel_hex_record_parser_unit.f =====
rtl/ihex_pkg.sv
rtl/ihex_parse.sv
rtl/intel_hex_record_parser_unit.sv
rtl/ihex_checker.sv
dv/testbench.sv
